[rtl/minimal_riscv_core_step_core_macros.svh]
// Assertion macros for the RV32 subset core
`ifndef MINIMAL_RISCV_CORE_STEP_CORE_MACROS_SVH
`define MINIMAL_RISCV_CORE_STEP_CORE_MACROS_SVH

// Implication checked on every edge outside reset
`define MRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define MRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mrc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants for the RV32 subset core.
// ----------------------------------------------------------------------------
package mrc_pkg;

  localparam int unsigned MemBytesDefault = 65536;
  localparam int unsigned NumRegsDefault  = 16;

  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_BYTE = 3'd0;
  localparam logic [2:0] F3_BYTEU = 3'd4;

  localparam logic OP_LOAD_WORD = 1'b0;
  localparam logic OP_EXEC      = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] load_address;
    logic [31:0] load_word;
  } req_t;

  typedef struct packed {
    logic [31:0] pc_now;
    logic        halted;
    logic        trap_good;
    logic        invalid_opcode;
    logic [31:0] a0_value;
  } rsp_t;

  // Byte-lane access from the sequencer to the memory
  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  we;
    logic [31:0] wdata;
  } mem_req_t;

endpackage

[rtl/mrc_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_mem
// Byte memory as four byte-wide banks; any unaligned word in one access.
// ----------------------------------------------------------------------------
module mrc_mem #(
  parameter int unsigned MEM_BYTES = mrc_pkg::MemBytesDefault
) (
  input  logic             clk,
  input  mrc_pkg::mem_req_t req,
  output logic [31:0]      rdata
);
  import mrc_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam int unsigned BD = MEM_BYTES / 4;
  localparam int unsigned BW = AW - 2;

  logic [7:0] bank0 [BD];
  logic [7:0] bank1 [BD];
  logic [7:0] bank2 [BD];
  logic [7:0] bank3 [BD];

  logic [AW-1:0] ba [4];
  logic [7:0]    wb [4];
  logic [3:0]    bwe;
  logic [7:0]    rb [4];
  logic [1:0]    rot;

  // Map byte lanes to banks
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ba[i] = req.addr[AW-1:0] + AW'(i);
    end
    for (int b = 0; b < 4; b++) begin
      wb[b]  = '0;
      bwe[b] = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (ba[i][1:0] == 2'(b)) begin
          wb[b]  = req.wdata[8*i +: 8];
          bwe[b] = req.we[i];
        end
      end
    end
  end

  logic [BW-1:0] bank_addr [4];
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_addr[b] = '0;
      for (int i = 0; i < 4; i++) begin
        if (ba[i][1:0] == 2'(b)) bank_addr[b] = ba[i][AW-1:2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bwe[0]) bank0[bank_addr[0]] <= wb[0];
    if (bwe[1]) bank1[bank_addr[1]] <= wb[1];
    if (bwe[2]) bank2[bank_addr[2]] <= wb[2];
    if (bwe[3]) bank3[bank_addr[3]] <= wb[3];
    rb[0] <= bank0[bank_addr[0]];
    rb[1] <= bank1[bank_addr[1]];
    rb[2] <= bank2[bank_addr[2]];
    rb[3] <= bank3[bank_addr[3]];
    rot   <= req.addr[1:0];
  end

  // Rotate banks back into byte order
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rdata[8*i +: 8] = rb[2'(rot + 2'(i))];
    end
  end
endmodule

[rtl/minimal_riscv_core_step_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minimal_riscv_core_step_core
// RV32 subset core stepped one request at a time.
// ----------------------------------------------------------------------------
// Each request returns one status response from an output register. A
// program-word write, or a step of a halted core, is done when accepted, and
// its response is then registered. An executed instruction goes through the
// fetch read, then execute (a store writes here), then the response capture.
// A load puts its data read between execute and capture. Every request's
// accesses go through the single-port byte memory in turn, one at a time.
// The next request is taken in the cycle in which the previous response
// leaves, so a new request is never taken while one is in progress.
// Unwritten memory reads back undefined data.
module minimal_riscv_core_step_core #(
  parameter int unsigned MEM_BYTES = mrc_pkg::MemBytesDefault,
  parameter int unsigned NUM_REGS  = mrc_pkg::NumRegsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  mrc_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mrc_pkg::rsp_t out_data
);
  import mrc_pkg::*;
  `include "minimal_riscv_core_step_core_macros.svh"

  localparam int unsigned RW = $clog2(NUM_REGS);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_MEM} state_t;

  state_t      state;
  logic [31:0] pc;
  logic [31:0] regs [NUM_REGS];
  logic        halt, bad;
  logic [31:0] inst;
  logic [RW-1:0] ld_rd;
  logic        ld_byte;
  logic        done;

  mem_req_t    mreq;
  logic [31:0] mrdata;

  mrc_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (.clk(clk), .req(mreq), .rdata(mrdata));

  logic accept;
  assign in_stall = (state != S_IDLE) || done || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  // Decode
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [RW-1:0] rd, rs1, rs2;
  logic [31:0] imm_i, imm_s, base, src2, sum_i;
  assign inst  = mrdata;
  assign opc   = inst[6:0];
  assign f3    = inst[14:12];
  assign rd    = inst[7 +: RW];
  assign rs1   = inst[15 +: RW];
  assign rs2   = inst[20 +: RW];
  assign imm_i = {{20{inst[31]}}, inst[31:20]};
  assign imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
  assign base  = regs[rs1];
  assign src2  = regs[rs2];
  assign sum_i = base + imm_i;

  // Drive memory port
  always_comb begin
    mreq = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_LOAD_WORD) begin
            mreq.addr  = {16'd0, in_data.load_address};
            mreq.we    = 4'hf;
            mreq.wdata = in_data.load_word;
          end else begin
            mreq.addr = pc;
          end
        end
      end
      S_EXEC: begin
        if (opc == OPC_LOAD) mreq.addr = sum_i;
        if (opc == OPC_STORE) begin
          mreq.addr  = base + imm_s;
          mreq.wdata = src2;
          if (f3 == F3_WORD) mreq.we = 4'hf;
          else if (f3 == F3_BYTE) mreq.we = 4'h1;
        end
      end
      default: mreq = '0;
    endcase
  end

  // Sequence requests and update architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      halt  <= 1'b0;
      bad   <= 1'b0;
      done  <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.op == OP_EXEC && !halt) state <= S_EXEC;
            else done <= 1'b1;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          done  <= 1'b1;
          pc    <= pc + 32'd4;
          case (opc)
            OPC_JALR: begin
              pc <= {sum_i[31:1], 1'b0};
              if (rd != '0) regs[rd] <= pc + 32'd4;
            end
            OPC_OPIMM: if (rd != '0) regs[rd] <= sum_i;
            OPC_OP: if (inst[31:25] == 7'd0 && rd != '0) regs[rd] <= base + src2;
            OPC_LUI: if (rd != '0) regs[rd] <= {inst[31:12], 12'd0};
            OPC_LOAD: begin
              if (f3 == F3_WORD || f3 == F3_BYTEU) begin
                state   <= S_MEM;
                done    <= 1'b0;
                ld_rd   <= rd;
                ld_byte <= (f3 == F3_BYTEU);
              end
            end
            OPC_STORE: ;
            OPC_SYSTEM: halt <= 1'b1;
            default: begin
              halt <= 1'b1;
              bad  <= 1'b1;
              pc   <= pc;
            end
          endcase
        end
        S_MEM: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (ld_rd != '0) regs[ld_rd] <= ld_byte ? {24'd0, mrdata[7:0]} : mrdata;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Capture the status once the request has finished, hold it until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_data  <= '0;
    end else if (done) begin
      out_valid               <= 1'b1;
      out_data.pc_now         <= pc;
      out_data.halted         <= halt;
      out_data.trap_good      <= halt && !bad && (regs[10] == '0);
      out_data.invalid_opcode <= bad;
      out_data.a0_value       <= regs[10];
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `MRC_ASSERT_IMP(a_no_accept_busy, clk, rst, state != S_IDLE, !accept,
                  "accept while busy")
  `MRC_ASSERT_NEXT(a_exec_after_fetch, clk, rst,
                   accept && in_data.op == OP_EXEC && !halt, state == S_EXEC,
                   "exec missing")
  `MRC_ASSERT_IMP(a_bad_halts, clk, rst, bad, halt, "bad without halt")
  `MRC_ASSERT_NEXT(a_mem_done, clk, rst, state == S_MEM, done && state == S_IDLE,
                   "load not finished")
  `MRC_ASSERT_NEXT(a_rsp_held, clk, rst, out_valid && out_stall,
                   out_valid && $stable(out_data), "stalled response changed")
endmodule

[sim/mrc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrc_checker
// Watches both channels of the RV32 subset core, predicts each status
// response from its own copy of the architectural state, and compares.
// ----------------------------------------------------------------------------
module mrc_checker
  import mrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  rsp_t out_data,
  output int   fail_count,
  output int   pending
);

  logic [31:0] pc_q;
  logic [31:0] regs_q [16];
  logic [7:0]  mem_q [0:65535];
  logic        halt_q;
  logic        bad_q;
  rsp_t        status_q [$];

  function automatic logic [31:0] mem_word(logic [31:0] a);
    logic [31:0] w;
    for (int i = 0; i < 4; i++) w[8*i +: 8] = mem_q[16'(a + i)];
    return w;
  endfunction

  // Execute one instruction on the shadow state
  task automatic run_one();
    logic [31:0] inst, base, imm_i, imm_s, nxt, ea;
    logic [3:0]  rd, rs1, rs2;
    logic [6:0]  opc;
    logic [2:0]  f3;
    inst  = mem_word(pc_q);
    opc   = inst[6:0];
    f3    = inst[14:12];
    rd    = inst[10:7];
    rs1   = inst[18:15];
    rs2   = inst[23:20];
    imm_i = {{20{inst[31]}}, inst[31:20]};
    imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
    base  = regs_q[rs1];
    nxt   = pc_q + 32'd4;
    case (opc)
      OPC_JALR: begin
        nxt = (base + imm_i) & ~32'd1;
        regs_q[rd] = pc_q + 32'd4;
      end
      OPC_OPIMM: regs_q[rd] = base + imm_i;
      OPC_OP: begin
        if (inst[31:25] == 7'd0) regs_q[rd] = base + regs_q[rs2];
      end
      OPC_LUI: regs_q[rd] = {inst[31:12], 12'd0};
      OPC_LOAD: begin
        ea = base + imm_i;
        if (f3 == F3_WORD) regs_q[rd] = mem_word(ea);
        else if (f3 == F3_BYTEU) regs_q[rd] = {24'd0, mem_q[ea[15:0]]};
      end
      OPC_STORE: begin
        ea = base + imm_s;
        if (f3 == F3_WORD) begin
          for (int i = 0; i < 4; i++) mem_q[16'(ea + i)] = regs_q[rs2][8*i +: 8];
        end else if (f3 == F3_BYTE) begin
          mem_q[ea[15:0]] = regs_q[rs2][7:0];
        end
      end
      OPC_SYSTEM: halt_q = 1'b1;
      default: begin
        halt_q = 1'b1;
        bad_q  = 1'b1;
        nxt    = pc_q;
      end
    endcase
    regs_q[0] = 32'd0;
    pc_q = nxt;
  endtask

  // Apply one request and work out the status it should return
  task automatic core_step(input req_t r, output rsp_t s);
    if (r.op == OP_LOAD_WORD) begin
      for (int i = 0; i < 4; i++) mem_q[16'(r.load_address + i)] = r.load_word[8*i +: 8];
    end else if (!halt_q) begin
      run_one();
    end
    s.pc_now         = pc_q;
    s.halted         = halt_q;
    s.trap_good      = halt_q && !bad_q && (regs_q[10] == 32'd0);
    s.invalid_opcode = bad_q;
    s.a0_value       = regs_q[10];
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Compare finished responses, then queue the prediction for a new request
  always @(posedge clk) begin
    rsp_t want, got;
    if (rst) begin
      pc_q   = 32'd0;
      halt_q = 1'b0;
      bad_q  = 1'b0;
      for (int i = 0; i < 16; i++) regs_q[i] = 32'd0;
      status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (status_q.size() == 0) begin
          $error("response with no request outstanding: %h", got);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          check_field("pc_now", want.pc_now, got.pc_now);
          check_field("halted", want.halted, got.halted);
          check_field("trap_good", want.trap_good, got.trap_good);
          check_field("invalid_opcode", want.invalid_opcode, got.invalid_opcode);
          check_field("a0_value", want.a0_value, got.a0_value);
        end
      end
      if (in_valid && !in_stall) begin
        core_step(in_data, want);
        status_q.push_back(want);
      end
    end
    pending <= status_q.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the RV32 subset core: each instruction is written at the
// current pc just before it is stepped, so fetches and loads only touch
// written memory. Directed corner cases come first, then random programs,
// and the run ends with a halt.
// ----------------------------------------------------------------------------
module tb_top;
  import mrc_pkg::*;

  localparam int ItemTarget = 1600;
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  int   fail_count;
  int   pending;

  // Stimulus-side tracking of the pc, register values and written bytes
  logic [31:0] pc_t;
  logic [31:0] regs_t [16];
  bit          known_t [16];
  bit          written_t [0:65535];
  logic [15:0] word_spots [$];
  bit          halted_t;
  bit          calm;
  int          n_req;
  int          n_steps;
  int          cycles;

  minimal_riscv_core_step_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  mrc_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the response side in random bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !calm && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [4:0] f5(logic [3:0] r);
    return {1'($urandom_range(0, 1)), r};
  endfunction

  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [3:0] rd, logic [2:0] f3,
                                        logic [3:0] rs1, logic [11:0] imm);
    return {imm, f5(rs1), f3, f5(rd), opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [2:0] f3, logic [3:0] rs1, logic [3:0] rs2,
                                        logic [11:0] imm);
    return {imm[11:5], f5(rs2), f5(rs1), f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [3:0] rd, logic [3:0] rs1,
                                        logic [3:0] rs2);
    return {f7, f5(rs2), f5(rs1), 3'($urandom), f5(rd), OPC_OP};
  endfunction

  function automatic logic [31:0] sext12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // Hand one request over, sometimes after a random gap
  task automatic send(req_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_req++;
    if (n_req >= ItemTarget - 250) calm = 1'b1;
  endtask

  task automatic put_word(logic [15:0] a, logic [31:0] w);
    req_t r;
    r.op           = OP_LOAD_WORD;
    r.load_address = a;
    r.load_word    = w;
    send(r);
    for (int i = 0; i < 4; i++) written_t[16'(a + i)] = 1'b1;
    word_spots.push_back(a);
  endtask

  task automatic put_reg(logic [3:0] rd, logic [31:0] v, bit k);
    if (rd != 4'd0) begin
      regs_t[rd]  = v;
      known_t[rd] = k;
    end
  endtask

  // Write the instruction at the pc, step it, then follow its effect
  task automatic run_inst(logic [31:0] inst);
    req_t        r;
    logic [31:0] base, ea, nxt;
    logic [3:0]  rd, rs1, rs2;
    put_word(pc_t[15:0], inst);
    r.op           = OP_EXEC;
    r.load_address = 16'($urandom);
    r.load_word    = $urandom;
    send(r);
    n_steps++;
    if (halted_t) return;
    rd   = inst[10:7];
    rs1  = inst[18:15];
    rs2  = inst[23:20];
    base = regs_t[rs1];
    nxt  = pc_t + 32'd4;
    case (inst[6:0])
      OPC_JALR: begin
        nxt = (base + sext12(inst[31:20])) & ~32'd1;
        put_reg(rd, pc_t + 32'd4, 1'b1);
      end
      OPC_OPIMM: put_reg(rd, base + sext12(inst[31:20]), known_t[rs1]);
      OPC_OP: begin
        if (inst[31:25] == 7'd0) put_reg(rd, base + regs_t[rs2], known_t[rs1] && known_t[rs2]);
      end
      OPC_LUI: put_reg(rd, {inst[31:12], 12'd0}, 1'b1);
      OPC_LOAD: begin
        if (inst[14:12] == F3_WORD || inst[14:12] == F3_BYTEU) put_reg(rd, 32'd0, 1'b0);
      end
      OPC_STORE: begin
        ea = base + sext12({inst[31:25], inst[11:7]});
        if (known_t[rs1] && inst[14:12] == F3_WORD) begin
          for (int i = 0; i < 4; i++) written_t[16'(ea + i)] = 1'b1;
          word_spots.push_back(ea[15:0]);
        end else if (known_t[rs1] && inst[14:12] == F3_BYTE) begin
          written_t[ea[15:0]] = 1'b1;
        end
      end
      OPC_SYSTEM: halted_t = 1'b1;
      default: begin
        halted_t = 1'b1;
        nxt      = pc_t;
      end
    endcase
    pc_t = nxt;
  endtask

  // Build an exact 32-bit value in a register with lui and addi
  task automatic set_value(logic [3:0] rd, logic [31:0] v);
    logic [31:0] hi;
    hi = v + 32'h800;
    run_inst({hi[31:12], f5(rd), OPC_LUI});
    run_inst(enc_i(OPC_OPIMM, rd, 3'($urandom), rd, v[11:0]));
  endtask

  // Load from an address known to be written
  task automatic load_at(logic [15:0] a, bit bytewise);
    logic [3:0]  rb;
    logic [11:0] imm;
    logic [15:0] lo;
    rb  = 4'($urandom_range(1, 15));
    imm = 12'($urandom);
    lo  = 16'(a - sext12(imm));
    set_value(rb, {16'($urandom), lo});
    run_inst(enc_i(OPC_LOAD, 4'($urandom), bytewise ? F3_BYTEU : F3_WORD, rb, imm));
  endtask

  task automatic jump_to(logic [31:0] target);
    logic [3:0]  rb;
    logic [11:0] imm;
    rb  = 4'($urandom_range(1, 15));
    imm = 12'($urandom);
    set_value(rb, target - sext12(imm));
    run_inst(enc_i(OPC_JALR, 4'($urandom), 3'($urandom), rb, imm));
  endtask

  task automatic random_step();
    logic [15:0] a;
    logic [2:0]  f3;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      run_inst(enc_i(OPC_OPIMM, 4'($urandom), 3'($urandom), 4'($urandom), 12'($urandom)));
    end else if (pick < 33) begin
      run_inst(enc_r(($urandom_range(0, 5) == 0) ? 7'($urandom) : 7'd0,
                     4'($urandom), 4'($urandom), 4'($urandom)));
    end else if (pick < 42) begin
      run_inst({20'($urandom), f5(4'($urandom)), OPC_LUI});
    end else if (pick < 57) begin
      a = word_spots[$urandom_range(0, word_spots.size() - 1)];
      if ($urandom_range(0, 1)) load_at(a + 16'($urandom_range(0, 3)), 1'b1);
      else load_at(a, 1'b0);
    end else if (pick < 72) begin
      f3 = $urandom_range(0, 1) ? F3_WORD : F3_BYTE;
      run_inst(enc_s(f3, 4'($urandom), 4'($urandom), 12'($urandom)));
    end else if (pick < 80) begin
      jump_to($urandom);
    end else if (pick < 90) begin
      put_word(16'($urandom), $urandom);
    end else if (pick < 95) begin
      do f3 = 3'($urandom); while (f3 == F3_WORD || f3 == F3_BYTEU);
      run_inst(enc_i(OPC_LOAD, 4'($urandom), f3, 4'($urandom), 12'($urandom)));
    end else begin
      do f3 = 3'($urandom); while (f3 == F3_WORD || f3 == F3_BYTE);
      run_inst(enc_s(f3, 4'($urandom), 4'($urandom), 12'($urandom)));
    end
  endtask

  initial begin
    logic [6:0] opc;
    bit         bad_end;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    calm     = 1'b0;
    halted_t = 1'b0;
    pc_t     = 32'd0;
    for (int i = 0; i < 16; i++) begin
      regs_t[i]  = 32'd0;
      known_t[i] = 1'b1;
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Immediate extremes, add, writes to x0 and aliased register fields
    run_inst(enc_i(OPC_OPIMM, 4'd1, 3'd0, 4'd0, 12'h7ff));
    run_inst(enc_i(OPC_OPIMM, 4'd2, 3'd7, 4'd0, 12'h800));
    run_inst({20'hfffff, 5'd3, OPC_LUI});
    run_inst(enc_r(7'd0, 4'd4, 4'd1, 4'd2));
    run_inst(enc_i(OPC_OPIMM, 4'd0, 3'd0, 4'd1, 12'd5));
    run_inst({12'hfff, 5'b11101, 3'd0, 5'b11010, OPC_OPIMM});
    // Malformed forms that only advance the pc
    run_inst(enc_r(7'h7f, 4'd5, 4'd1, 4'd2));
    run_inst(enc_i(OPC_LOAD, 4'd6, 3'd7, 4'd1, 12'd0));
    run_inst(enc_s(3'd7, 4'd1, 4'd3, 12'd0));
    // Stores and loads that straddle the end of memory
    set_value(4'd5, 32'hfffffffd);
    run_inst(enc_s(F3_WORD, 4'd5, 4'd3, 12'd0));
    run_inst(enc_s(F3_BYTE, 4'd5, 4'd1, 12'd2));
    put_word(16'hfffe, 32'ha5c3_0ff0);
    load_at(16'hfffe, 1'b0);
    load_at(16'hffff, 1'b1);
    // Odd jump target lands on a fetch that straddles the end of memory
    jump_to(32'h1234_ffff);
    run_inst(enc_i(OPC_OPIMM, 4'd10, 3'd0, 4'd10, 12'd1));

    // Random programs
    while (n_req < ItemTarget - 8) begin
      random_step();
      if (n_req > 700 && n_req < 710) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
    end

    // Halt on a system or an unknown opcode, then show that steps do nothing
    bad_end = $urandom_range(0, 1);
    if (!bad_end && $urandom_range(0, 1)) run_inst(enc_i(OPC_OPIMM, 4'd10, 3'd0, 4'd0, 12'd0));
    if (bad_end) begin
      do opc = 7'($urandom);
      while (opc inside {OPC_JALR, OPC_OPIMM, OPC_OP, OPC_LUI, OPC_LOAD, OPC_STORE,
                         OPC_SYSTEM});
      run_inst({25'($urandom), opc});
    end else begin
      run_inst({25'($urandom), OPC_SYSTEM});
    end
    run_inst($urandom);
    put_word(16'($urandom), $urandom);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d requests, %0d of them instruction steps, ending on a %s halt.",
             n_req, n_steps, bad_end ? "bad-opcode" : "system");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
